// ----- rtl/core/f2h_pkg.sv -----
// Package for the float32 to float16 tile reorder block.
// Holds layout constants, mode codes and the conversion function; no dependencies.
package f2h_pkg;
	localparam int TILE_ROWS = 16;
	localparam int TILE_COLS = 8;
	localparam logic [13:0] MAX_ROWS = 14'd10240;
	localparam logic [12:0] MAX_COLS = 13'd4096;

	typedef enum logic [0:0] {
		MODE_KEEP = 1'b0,
		MODE_TILE = 1'b1
	} layout_mode_t;

	typedef enum logic [1:0] {
		REG_LAYOUT = 2'd0,
		REG_ROWS   = 2'd1,
		REG_COLS   = 2'd2
	} reg_index_t;

	function automatic logic [15:0] f32_to_f16(input logic [31:0] x);
		logic        sgn;
		logic [7:0]  ex;
		logic [22:0] man;
		logic [8:0]  e;
		logic [9:0]  h;
		logic [14:0] hn;
		logic [12:0] rem;
		logic [23:0] m;
		logic [4:0]  sh;
		logic [23:0] sm;
		logic [23:0] rm;
		logic [23:0] hf;
		logic [10:0] hs;
		begin
			sgn = x[31];
			ex  = x[30:23];
			man = x[22:0];
			e   = {1'b0, ex} - 9'd112;
			h   = man[22:13];
			rem = man[12:0];
			hn  = {e[4:0], h};
			m   = {1'b1, man};
			sh  = 5'd0;
			sm  = 24'd0;
			rm  = 24'd0;
			hf  = 24'd0;
			hs  = 11'd0;
			if (ex == 8'hff) begin
				if (man != 23'd0) f32_to_f16 = {sgn, 5'b11111, 1'b1, man[21:13]};
				else f32_to_f16 = {sgn, 15'h7c00};
			end else if (ex >= 8'd143) begin
				f32_to_f16 = {sgn, 15'h7c00};
			end else if (ex >= 8'd113) begin
				if (rem > 13'h1000 || (rem == 13'h1000 && h[0])) hn = hn + 15'd1;
				f32_to_f16 = {sgn, hn};
			end else if (ex < 8'd102) begin
				f32_to_f16 = {sgn, 15'd0};
			end else begin
				sh = 5'(8'd126 - ex);
				sm = m >> sh;
				rm = m & ((24'd1 << sh) - 24'd1);
				hf = 24'd1 << (sh - 5'd1);
				hs = sm[10:0];
				if (rm > hf || (rm == hf && hs[0])) hs = hs + 11'd1;
				f32_to_f16 = {sgn, 4'd0, hs};
			end
		end
	endfunction
endpackage

// ----- rtl/core/fp32_to_fp16_tile_reorder.sv -----
// Top level of the float32 to float16 converter with destination index generation.
// Depends on f2h_pkg.
// One item per cycle while in_stall is low: a word is converted and indexed in one stage after the
// input register; the tile stride (row tiles) is precomputed from the row count, so
// the per-item path holds one 9x10 multiply or one 14x13 multiply and an add.
// An output register with a skid stage lets input transfers continue while the
// consumer stalls, until the skid stage holds an item.
module fp32_to_fp16_tile_reorder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] single_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] half_word,
	output logic [25:0] dest_index,
	output logic        last
);
	import f2h_pkg::*;

	layout_mode_t mode_q;
	logic [13:0] rows_q;
	logic [12:0] cols_q;
	logic [13:0] row_pos_q;
	logic [11:0] col_pos_q;
	logic [13:0] rows_c;
	logic [12:0] cols_c;
	logic [9:0]  trows_c;

	logic        v_s1;
	logic [31:0] w_s1;
	logic [13:0] r_s1;
	logic [11:0] c_s1;
	logic        l_s1;

	logic        in_fire;
	logic        adv;
	logic        col_end;
	logic        row_end;
	logic [25:0] idx;
	logic [15:0] hw;
	logic [18:0] tmul;
	logic [26:0] kmul;

	logic        ov_q, sv_q;
	logic [15:0] oh_q, sh_q;
	logic [25:0] oi_q, si_q;
	logic        ol_q, sl_q;

	always_comb begin
		rows_c = (rows_q == 14'd0) ? 14'd1 : ((rows_q > MAX_ROWS) ? MAX_ROWS : rows_q);
		cols_c = (cols_q == 13'd0) ? 13'd1 : ((cols_q > MAX_COLS) ? MAX_COLS : cols_q);
		trows_c = 10'((15'(rows_c) + 15'd15) >> 4);
		col_end = (13'(col_pos_q) + 13'd1) >= cols_c;
		row_end = (14'(row_pos_q) + 14'd1) >= rows_c;
	end

	assign in_stall = sv_q;
	assign in_fire  = in_valid && !in_stall;
	assign adv      = !sv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_TILE;
			rows_q    <= 14'd16;
			cols_q    <= 13'd8;
			row_pos_q <= 14'd0;
			col_pos_q <= 12'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LAYOUT: mode_q <= layout_mode_t'(cfg_data[0]);
					REG_ROWS:   rows_q <= cfg_data;
					REG_COLS:   cols_q <= cfg_data[12:0];
					default:    ;
				endcase
			end
			if (in_fire) begin
				if (col_end) begin
					col_pos_q <= 12'd0;
					row_pos_q <= row_end ? 14'd0 : row_pos_q + 14'd1;
				end else begin
					col_pos_q <= col_pos_q + 12'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_fire;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			w_s1 <= single_word;
			r_s1 <= row_pos_q;
			c_s1 <= col_pos_q;
			l_s1 <= col_end && row_end;
		end
	end

	logic [12:0] mode_s1_cols;
	logic [9:0]  trows_s1;
	layout_mode_t md_s1;
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1_cols <= cols_c;
			trows_s1     <= trows_c;
			md_s1        <= mode_q;
		end
	end

	always_comb begin
		hw = f32_to_f16(w_s1);
		tmul = c_s1[11:3] * trows_s1;
		kmul = r_s1 * mode_s1_cols;
		if (md_s1 == MODE_TILE)
			idx = {tmul, 7'd0} + 26'({r_s1[13:4], 7'd0})
				+ 26'({c_s1[2:0], 4'd0}) + 26'(r_s1[3:0]);
		else
			idx = kmul[25:0] + 26'(c_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else begin
			if (!ov_q || !out_stall) begin
				ov_q <= sv_q || v_s1;
				sv_q <= 1'b0;
			end else if (v_s1 && !sv_q) begin
				sv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!ov_q || !out_stall) begin
			if (sv_q) begin
				oh_q <= sh_q; oi_q <= si_q; ol_q <= sl_q;
			end else begin
				oh_q <= hw; oi_q <= idx; ol_q <= l_s1;
			end
		end else if (v_s1 && !sv_q) begin
			sh_q <= hw; si_q <= idx; sl_q <= l_s1;
		end
	end

	assign out_valid  = ov_q;
	assign half_word  = oh_q;
	assign dest_index = oi_q;
	assign last       = ol_q;
endmodule
